// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/tvm_pkg.sv =====
// shared types, constants and the rotate function of the word machine
package tvm_pkg;

	localparam int MEM_WORDS = 32768;
	localparam int MEM_AW = $clog2(MEM_WORDS);
	localparam int REG_AW = 3;

	localparam logic [15:0] LOW15 = 16'o077777;
	localparam logic [15:0] SIGN_BIT = 16'o100000;
	localparam logic [14:0] CTRL_ADDR = 15'o77770;
	localparam logic [14:0] CHAR_OUT_ADDR = 15'o77771;
	localparam logic [14:0] CHAR_IN_ADDR = 15'o77772;
	localparam logic [15:0] IMM_MASK = 16'o000776;
	localparam logic [14:0] ROT_FULL = 15'o77760;
	localparam logic [2:0] PC_REG = 3'd7;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_STEP = 2'd2;
	localparam logic [1:0] OP_RESTART = 2'd3;

	typedef struct packed {
		logic we;
		logic [MEM_AW-1:0] waddr;
		logic [15:0] wdata;
		logic [MEM_AW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic we;
		logic [REG_AW-1:0] waddr;
		logic [15:0] wdata;
		logic [REG_AW-1:0] raddr;
	} reg_req_t;

	function automatic logic [15:0] rot_word(input logic [15:0] x, input logic [14:0] n);
		logic [3:0] r;
		logic [3:0] l;
		logic [31:0] xl;
		logic [15:0] res;
		r = n[3:0];
		l = 4'd15 - r;
		xl = {16'd0, x} << l;
		if ((n & ROT_FULL) == ROT_FULL) begin
			res = xl[15:0] | (x >> r);
		end else begin
			res = (x & SIGN_BIT) | (xl[15:0] & LOW15) | ((x & LOW15) >> r);
		end
		return res;
	endfunction

endpackage

// ===== hdl/tvm_ram.sv =====
// simple dual-port synchronous ram with registered read
module tvm_ram #(
	parameter int AW = 15,
	parameter int DW = 16
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [DW-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// ===== hdl/tvm_ctrl.sv =====
// sequencer: clearing pass, load, read, restart, i/o slot service and instruction execution
module tvm_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic [1:0] operation,
	input logic [14:0] address,
	input logic [15:0] data,
	input logic [15:0] in_char,
	output logic res_valid,
	input logic res_stall,
	output logic [15:0] pc,
	output logic [15:0] read_data,
	output logic out_valid,
	output logic [7:0] out_char,
	output logic halted,
	output tvm_pkg::mem_req_t mem_req,
	input logic [15:0] mem_rdata,
	output tvm_pkg::reg_req_t reg_req,
	input logic [15:0] reg_rdata
);
	import tvm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CTL, S_SVC_OUT, S_CLRBIT, S_FETCH, S_DEC,
		S_OPV, S_OPT, S_LD, S_SKIP, S_SK2, S_FIN
	} state_t;

	state_t state_q;
	logic clearing_q;
	logic [MEM_AW-1:0] clr_q;
	logic [15:0] pc_q;
	logic [2:0] slot_q;
	logic stop_q;
	logic [15:0] ich_q;
	logic [15:0] ctl_q;
	logic [15:0] ir_q;
	logic [14:0] v_q;
	logic [15:0] cnew_q;
	logic fw_q;
	logic [15:0] t_q;
	logic [15:0] rd_q;
	logic ov_q;
	logic [7:0] oc_q;
	logic res_v_q;
	logic [15:0] res_pc_q;
	logic [15:0] res_rd_q;
	logic res_ov_q;
	logic [7:0] res_oc_q;
	logic res_halt_q;

	logic accept;
	logic [2:0] slot_next;
	logic [15:0] slot_bit;
	logic [2:0] f_i, f_m, f_c, f_a, f_q;
	logic [15:0] rc;
	logic [15:0] ta;
	logic [14:0] v;
	logic [15:0] cnew;
	logic [15:0] tnew;
	logic skip;
	logic two;

	assign accept = req_valid && !req_stall;
	assign req_stall = clearing_q || (state_q != S_IDLE);
	assign slot_next = (slot_q == 3'd7) ? 3'd1 : 3'(slot_q + 3'd1);
	assign slot_bit = 16'd1 << slot_q;
	assign f_i = ir_q[2:0];
	assign f_m = ir_q[5:3];
	assign f_c = ir_q[8:6];
	assign f_a = ir_q[11:9];
	assign f_q = ir_q[14:12];
	assign rc = (f_c == PC_REG) ? pc_q : reg_rdata;
	assign ta = (f_a == PC_REG) ? pc_q : (fw_q ? cnew_q : reg_rdata);
	assign two = (mem_rdata & IMM_MASK) == IMM_MASK;

	always_comb begin
		v = 15'd0;
		cnew = rc;
		case (f_m)
			3'd0: v = {12'd0, f_c};
			3'd1: v = {12'o7777, f_c};
			3'd2: v = 15'(16'd1 << (4'd3 + {1'b0, f_c}));
			3'd3: v = 15'((16'd1 << (4'd4 + {1'b0, f_c})) - 16'd1);
			3'd4: v = rc[14:0];
			3'd5: v = 15'(16'd0 - rc);
			3'd6: begin
				v = 15'(rc - 16'd1);
				cnew = {1'b0, v};
			end
			default: begin
				v = rc[14:0];
				cnew = {1'b0, 15'(rc[14:0] + 15'd1)};
			end
		endcase
	end

	always_comb begin
		tnew = ta;
		case (f_i)
			3'd0: tnew = {1'b0, v_q};
			3'd1: tnew = ta | {1'b0, v_q};
			3'd2: tnew = ta ^ {1'b0, v_q};
			3'd3: tnew = ta & (SIGN_BIT | {1'b0, v_q});
			3'd4: tnew = rot_word(ta, v_q);
			3'd5: tnew = (ta & LOW15) + {1'b0, v_q};
			default: tnew = ta;
		endcase
	end

	always_comb begin
		case (f_q)
			3'd0: skip = 1'b0;
			3'd1: skip = 1'b1;
			3'd2: skip = t_q[14:0] == 15'd0;
			3'd3: skip = t_q[14:0] != 15'd0;
			3'd4: skip = !t_q[15];
			3'd5: skip = t_q[15];
			3'd6: skip = (t_q[14:0] == 15'd0) || !t_q[15];
			default: skip = (t_q[14:0] != 15'd0) && t_q[15];
		endcase
	end

	always_comb begin
		mem_req = '0;
		reg_req = '0;
		if (clearing_q) begin
			mem_req.we = 1'b1;
			mem_req.waddr = clr_q;
			reg_req.we = 1'b1;
			reg_req.waddr = clr_q[REG_AW-1:0];
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && operation == OP_LOAD) begin
						mem_req.we = 1'b1;
						mem_req.waddr = address;
						mem_req.wdata = data;
					end
					mem_req.raddr = (operation == OP_READ) ? address : CTRL_ADDR;
				end
				S_CTL: begin
					mem_req.raddr = CHAR_OUT_ADDR;
					if (!mem_rdata[0] && (mem_rdata & slot_bit) != 16'd0
						&& slot_q == 3'd2) begin
						mem_req.we = 1'b1;
						mem_req.waddr = CHAR_IN_ADDR;
						mem_req.wdata = ich_q;
					end
				end
				S_SVC_OUT, S_CLRBIT: begin
					mem_req.we = 1'b1;
					mem_req.waddr = CTRL_ADDR;
					mem_req.wdata = ctl_q ^ slot_bit;
				end
				S_FETCH: mem_req.raddr = pc_q[14:0];
				S_DEC: reg_req.raddr = mem_rdata[8:6];
				S_OPV: begin
					reg_req.raddr = f_a;
					if (f_m[2:1] == 2'b11 && f_c != PC_REG) begin
						reg_req.we = 1'b1;
						reg_req.waddr = f_c;
						reg_req.wdata = cnew;
					end
				end
				S_OPT: begin
					mem_req.raddr = v_q;
					if (f_i == 3'd7) begin
						mem_req.we = 1'b1;
						mem_req.waddr = v_q;
						mem_req.wdata = ta & LOW15;
					end
					if (f_i != 3'd6 && f_a != PC_REG) begin
						reg_req.we = 1'b1;
						reg_req.waddr = f_a;
						reg_req.wdata = tnew;
					end
				end
				S_LD: begin
					if (f_a != PC_REG) begin
						reg_req.we = 1'b1;
						reg_req.waddr = f_a;
						reg_req.wdata = mem_rdata & LOW15;
					end
				end
				S_SKIP: mem_req.raddr = pc_q[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			clearing_q <= 1'b1;
			clr_q <= '0;
			pc_q <= '0;
			slot_q <= '0;
			stop_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (res_v_q && !res_stall && state_q != S_FIN) begin
				res_v_q <= 1'b0;
			end
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (&clr_q) begin
					clearing_q <= 1'b0;
				end
			end else begin
				case (state_q)
					S_IDLE: begin
						if (accept) begin
							rd_q <= '0;
							ov_q <= 1'b0;
							oc_q <= '0;
							ich_q <= in_char;
							case (operation)
								OP_LOAD: state_q <= S_FIN;
								OP_READ: state_q <= S_RD;
								OP_RESTART: begin
									pc_q <= '0;
									stop_q <= 1'b0;
									state_q <= S_FIN;
								end
								default: begin
									if (stop_q) begin
										state_q <= S_FIN;
									end else begin
										slot_q <= slot_next;
										state_q <= S_CTL;
									end
								end
							endcase
						end
					end
					S_RD: begin
						rd_q <= mem_rdata;
						state_q <= S_FIN;
					end
					S_CTL: begin
						ctl_q <= mem_rdata;
						if (mem_rdata[0]) begin
							stop_q <= 1'b1;
							state_q <= S_FIN;
						end else if ((mem_rdata & slot_bit) != 16'd0) begin
							state_q <= (slot_q == 3'd1) ? S_SVC_OUT : S_CLRBIT;
						end else begin
							state_q <= S_FETCH;
						end
					end
					S_SVC_OUT: begin
						ov_q <= 1'b1;
						oc_q <= mem_rdata[7:0];
						state_q <= S_FETCH;
					end
					S_CLRBIT: state_q <= S_FETCH;
					S_FETCH: begin
						pc_q <= {1'b0, 15'(pc_q[14:0] + 15'd1)};
						state_q <= S_DEC;
					end
					S_DEC: begin
						ir_q <= mem_rdata;
						state_q <= S_OPV;
					end
					S_OPV: begin
						v_q <= v;
						cnew_q <= cnew;
						fw_q <= (f_m[2:1] == 2'b11) && (f_c == f_a);
						if (f_m[2:1] == 2'b11 && f_c == PC_REG) begin
							pc_q <= cnew;
						end
						state_q <= S_OPT;
					end
					S_OPT: begin
						t_q <= tnew;
						if (f_i != 3'd6 && f_a == PC_REG) begin
							pc_q <= tnew;
						end
						state_q <= (f_i == 3'd6) ? S_LD : S_SKIP;
					end
					S_LD: begin
						t_q <= mem_rdata & LOW15;
						if (f_a == PC_REG) begin
							pc_q <= mem_rdata & LOW15;
						end
						state_q <= S_SKIP;
					end
					S_SKIP: state_q <= skip ? S_SK2 : S_FIN;
					S_SK2: begin
						pc_q <= {1'b0, 15'(pc_q[14:0] + 15'd1 + {14'd0, two})};
						state_q <= S_FIN;
					end
					S_FIN: begin
						if (!res_v_q || !res_stall) begin
							res_v_q <= 1'b1;
							res_pc_q <= pc_q;
							res_rd_q <= rd_q;
							res_ov_q <= ov_q;
							res_oc_q <= oc_q;
							res_halt_q <= stop_q;
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign res_valid = res_v_q;
	assign pc = res_pc_q;
	assign read_data = res_rd_q;
	assign out_valid = res_ov_q;
	assign out_char = res_oc_q;
	assign halted = res_halt_q;

endmodule

// ===== hdl/tiny_word_vm_core_top.sv =====
// top level of the word machine: sequencer, main memory and register file
//
// channel  direction  transfer when            fields
// req      in         req_valid & !req_stall   operation address data in_char
// res      out        res_valid & !res_stall   pc read_data out_valid out_char halted
//
// load and restart go to the finish state directly, read through a read state; a step
// ends at once when stopped and after the control word read when it halts, else goes on
// through fetch, decode, operand, operation and skip test (slot service, load and a
// taken skip add a state each; all use the single read port of the main memory)
// after reset a clearing pass zeroes memory and registers; req_stall stays high meanwhile
// one item at a time; the result register lets the next item in while it waits
module tiny_word_vm_core_top (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input logic [1:0] operation,
	input logic [14:0] address,
	input logic [15:0] data,
	input logic [15:0] in_char,
	output logic res_valid,
	input logic res_stall,
	output logic [15:0] pc,
	output logic [15:0] read_data,
	output logic out_valid,
	output logic [7:0] out_char,
	output logic halted
);
	import tvm_pkg::*;

	mem_req_t mem_req;
	reg_req_t reg_req;
	logic [15:0] mem_rdata;
	logic [15:0] reg_rdata;

	tvm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.operation(operation), .address(address), .data(data), .in_char(in_char),
		.res_valid(res_valid), .res_stall(res_stall),
		.pc(pc), .read_data(read_data), .out_valid(out_valid),
		.out_char(out_char), .halted(halted),
		.mem_req(mem_req), .mem_rdata(mem_rdata),
		.reg_req(reg_req), .reg_rdata(reg_rdata)
	);

	tvm_ram #(.AW(MEM_AW), .DW(16)) u_mem (
		.clk(clk), .we(mem_req.we), .waddr(mem_req.waddr),
		.wdata(mem_req.wdata), .raddr(mem_req.raddr), .rdata(mem_rdata)
	);

	tvm_ram #(.AW(REG_AW), .DW(16)) u_regs (
		.clk(clk), .we(reg_req.we), .waddr(reg_req.waddr),
		.wdata(reg_req.wdata), .raddr(reg_req.raddr), .rdata(reg_rdata)
	);

endmodule

// ===== hdl/tvm_checker.sv =====
// port-level checker of the word machine and its bind
`include "assert_macros.svh"

module tvm_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic res_valid,
	input logic res_stall,
	input logic [15:0] pc,
	input logic out_valid,
	input logic [7:0] out_char,
	input logic halted
);

	`ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall)
	`ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
	`ASSERT_NEXT(a_pc_hold, res_valid && res_stall, $stable(pc))
	`ASSERT_NOW(a_out_not_halted, res_valid && out_valid, !halted)
	`ASSERT_NOW(a_char_zero, res_valid && !out_valid, out_char == 8'd0)

endmodule

bind tiny_word_vm_core_top tvm_checker u_tvm_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req_valid), .req_stall(req_stall),
	.res_valid(res_valid), .res_stall(res_stall),
	.pc(pc), .out_valid(out_valid), .out_char(out_char), .halted(halted)
);
